// ----- sv/bcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bcpe_pkg: shared definitions for the Bezier curve point evaluator
// Field widths, fixed-point constants, command codes and the
// controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  // defaults for the top-level parameters
  localparam int MaxPointsDef = 16;
  localparam int CoordBitsDef = 16;

  // port field widths
  localparam int FieldW = 16;
  localparam int TW     = 17;
  localparam int UsedW  = 5;

  // fixed-point constants
  localparam int FracExtra = 14;
  localparam logic [TW-1:0] TOne = 17'h10000;

  // input command codes
  localparam logic CmdAppend = 1'b0;
  localparam logic CmdEval   = 1'b1;

  // controller commands to the datapath
  typedef struct packed {
    logic load_wr;     // write the returned store entry into the work row
    logic latch_t;     // capture t from the input transfer
    logic mul;         // register the four lerp products
    logic shift_lerp;  // rotate the work row, inserting the lerp result
    logic shift_move;  // rotate the work row, inserting the head entry
    logic fin;         // round, saturate and register the result
    logic fin_zero;    // result is the origin
  } bcpe_cmd_t;

endpackage

`default_nettype wire

// ----- sv/bcpe_in_if.sv -----
// ----------------------------------------------------------------------------
// bcpe_in_if: input channel of the Bezier curve point evaluator
// Valid/ready channel carrying the command, a control point and t.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpe_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic        [16:0] param_t;

  modport source (output valid, cmd, point_x, point_y, param_t, input ready);
  modport sink   (input valid, cmd, point_x, point_y, param_t, output ready);
endinterface

`default_nettype wire

// ----- sv/bcpe_out_if.sv -----
// ----------------------------------------------------------------------------
// bcpe_out_if: result channel of the Bezier curve point evaluator
// Valid/ready channel carrying the curve point and the point count.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] curve_x;
  logic signed [15:0] curve_y;
  logic        [4:0]  points_used;

  modport source (output valid, curve_x, curve_y, points_used, input ready);
  modport sink   (input valid, curve_x, curve_y, points_used, output ready);
endinterface

`default_nettype wire

// ----- sv/bcpe_ram.sv -----
// ----------------------------------------------------------------------------
// bcpe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/bcpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcpe_ctrl: controller of the Bezier curve point evaluator
// Keeps the point count, sequences store reads and the de Casteljau levels,
// and owns the input ready and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ctrl
  import bcpe_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_cmd_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              ram_we_o,
  output logic [$clog2(MaxPoints)-1:0]      ram_waddr_o,
  output logic [$clog2(MaxPoints)-1:0]      ram_raddr_o,
  output logic [$clog2(MaxPoints)-1:0]      load_idx_o,
  output logic [$clog2(MaxPoints)-1:0]      tail_o,
  output logic [$clog2(MaxPoints+1)-1:0]    cnt_o,
  output bcpe_cmd_t                         cmd_o
);

  localparam int AW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxPoints);
  localparam logic [CW-1:0] CntOne = CW'(1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLoad  = 7'b0000010,
    StLwait = 7'b0000100,
    StMul   = 7'b0001000,
    StAdd   = 7'b0010000,
    StMove  = 7'b0100000,
    StFin   = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] lvl_q, lvl_d;
  logic          out_valid_q, out_valid_d;
  logic          ld_vld_q, ld_vld_d;
  logic [AW-1:0] ld_idx_q, ld_idx_d;
  logic [CW-1:0] last_idx;
  logic          in_xfer;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign last_idx   = cnt_q - CntOne;

  // next-state logic and command decode
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    lvl_d       = lvl_q;
    ld_vld_d    = 1'b0;
    ld_idx_d    = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we_o    = 1'b0;
    cmd_o       = '0;
    cmd_o.load_wr = ld_vld_q;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_cmd_i == CmdAppend) begin
            if (count_q < CntMax) begin
              ram_we_o = 1'b1;
              count_d  = count_q + CntOne;
            end
          end else begin
            cmd_o.latch_t = 1'b1;
            cnt_d = count_q;
            idx_d = '0;
            if (count_q == '0) begin
              state_d = StFin;
            end else begin
              state_d = StLoad;
            end
          end
        end
      end
      StLoad: begin
        ld_vld_d = 1'b1;
        ld_idx_d = idx_q;
        if (CW'(idx_q) == last_idx) begin
          state_d = StLwait;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      StLwait: begin
        lvl_d = last_idx[AW-1:0];
        idx_d = '0;
        if (last_idx == '0) begin
          state_d = StFin;
        end else begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdd;
      end
      StAdd: begin
        cmd_o.shift_lerp = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q + AW'(1) == lvl_q) begin
          state_d = StMove;
        end else begin
          state_d = StMul;
        end
      end
      StMove: begin
        cmd_o.shift_move = 1'b1;
        lvl_d = lvl_q - AW'(1);
        idx_d = '0;
        if (lvl_q == AW'(1)) begin
          state_d = StFin;
        end else begin
          state_d = StMul;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin      = 1'b1;
          cmd_o.fin_zero = (cnt_q == '0);
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      ld_vld_q    <= 1'b0;
      ld_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      ld_vld_q    <= ld_vld_d;
      ld_idx_q    <= ld_idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_raddr_o = idx_q;
  assign load_idx_o  = ld_idx_q;
  assign tail_o      = lvl_q;
  assign cnt_o       = cnt_q;

endmodule

`default_nettype wire

// ----- sv/bcpe_dpath.sv -----
// ----------------------------------------------------------------------------
// bcpe_dpath: datapath of the Bezier curve point evaluator
// Work row of widened points, the lerp multipliers and adder, and the
// rounding, saturation and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_dpath
  import bcpe_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire bcpe_cmd_t                    cmd_i,
  input  wire logic [TW-1:0]                param_t_i,
  input  wire logic [2*CoordBits-1:0]       ram_rdata_i,
  input  wire logic [$clog2(MaxPoints)-1:0] load_idx_i,
  input  wire logic [$clog2(MaxPoints)-1:0] tail_i,
  input  wire logic [$clog2(MaxPoints+1)-1:0] cnt_i,
  output logic signed [FieldW-1:0]          curve_x_o,
  output logic signed [FieldW-1:0]          curve_y_o,
  output logic [UsedW-1:0]                  points_used_o
);

  localparam int AW   = $clog2(MaxPoints);
  localparam int CW   = $clog2(MaxPoints + 1);
  localparam int WW   = CoordBits + FracExtra;  // work value width
  localparam int PW   = WW + TW + 1;            // product width
  localparam int SW   = PW + 1;                 // lerp sum width
  localparam int FW   = WW + 1;                 // final rounding width
  localparam int EXTW = (CoordBits > FieldW) ? CoordBits : FieldW;
  localparam int UW   = (CW > UsedW) ? CW : UsedW;
  localparam logic signed [SW-1:0] LerpHalf = SW'(32768);
  localparam logic signed [FW-1:0] FinHalf  = FW'(1 << (FracExtra - 1));
  localparam logic signed [FW-1:0] SatHi    = FW'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
  localparam logic signed [FW-1:0] SatLo    = -SatHi - FW'(1);

  logic        [TW-1:0]  t_q;
  logic        [TW-1:0]  omt;
  logic signed [WW-1:0]  wx_q [MaxPoints];
  logic signed [WW-1:0]  wy_q [MaxPoints];
  logic signed [PW-1:0]  pxa_q, pxb_q, pya_q, pyb_q;
  logic signed [SW-1:0]  sx, sy, sx_sh, sy_sh;
  logic signed [WW-1:0]  new_x, new_y, ins_x, ins_y;
  logic signed [FW-1:0]  fx, fy, rx, ry;
  logic signed [CoordBits-1:0] cx, cy;
  logic signed [EXTW-1:0] ex, ey;
  logic signed [WW-1:0]  ld_x, ld_y;
  logic [UW-1:0]         used_ext;
  logic signed [FieldW-1:0] curve_x_q, curve_y_q;
  logic [UsedW-1:0]      used_q;

  assign omt = TOne - t_q;

  // lerp sum with round-half-up, then floor shift
  always_comb begin
    sx    = SW'(pxa_q) + SW'(pxb_q) + LerpHalf;
    sy    = SW'(pya_q) + SW'(pyb_q) + LerpHalf;
    sx_sh = sx >>> 16;
    sy_sh = sy >>> 16;
    new_x = sx_sh[WW-1:0];
    new_y = sy_sh[WW-1:0];
    ins_x = cmd_i.shift_lerp ? new_x : wx_q[0];
    ins_y = cmd_i.shift_lerp ? new_y : wy_q[0];
  end

  // store entry widened by the extra fraction bits
  assign ld_x = {ram_rdata_i[CoordBits-1:0], {FracExtra{1'b0}}};
  assign ld_y = {ram_rdata_i[2*CoordBits-1:CoordBits], {FracExtra{1'b0}}};

  // final rounding and saturation
  always_comb begin
    fx = FW'(wx_q[0]) + FinHalf;
    fy = FW'(wy_q[0]) + FinHalf;
    rx = fx >>> FracExtra;
    ry = fy >>> FracExtra;
    if (rx > SatHi) begin
      cx = SatHi[CoordBits-1:0];
    end else if (rx < SatLo) begin
      cx = SatLo[CoordBits-1:0];
    end else begin
      cx = rx[CoordBits-1:0];
    end
    if (ry > SatHi) begin
      cy = SatHi[CoordBits-1:0];
    end else if (ry < SatLo) begin
      cy = SatLo[CoordBits-1:0];
    end else begin
      cy = ry[CoordBits-1:0];
    end
    ex       = EXTW'(cx);
    ey       = EXTW'(cy);
    used_ext = UW'(cnt_i);
  end

  // t capture, saturated to one
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_t) begin
      t_q <= (param_t_i > TOne) ? TOne : param_t_i;
    end
  end

  // lerp products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pxa_q <= wx_q[0] * $signed({1'b0, omt});
      pxb_q <= wx_q[1 % MaxPoints] * $signed({1'b0, t_q});
      pya_q <= wy_q[0] * $signed({1'b0, omt});
      pyb_q <= wy_q[1 % MaxPoints] * $signed({1'b0, t_q});
    end
  end

  // work row: load from the store, or rotate the active part left
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxPoints; k++) begin
      if (cmd_i.load_wr) begin
        if (load_idx_i == AW'(k)) begin
          wx_q[k] <= ld_x;
          wy_q[k] <= ld_y;
        end
      end else if (cmd_i.shift_lerp || cmd_i.shift_move) begin
        if (AW'(k) < tail_i) begin
          wx_q[k] <= wx_q[(k + 1) % MaxPoints];
          wy_q[k] <= wy_q[(k + 1) % MaxPoints];
        end else if (AW'(k) == tail_i) begin
          wx_q[k] <= ins_x;
          wy_q[k] <= ins_y;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      curve_x_q <= cmd_i.fin_zero ? '0 : ex[FieldW-1:0];
      curve_y_q <= cmd_i.fin_zero ? '0 : ey[FieldW-1:0];
      used_q    <= used_ext[UsedW-1:0];
    end
  end

  assign curve_x_o     = curve_x_q;
  assign curve_y_o     = curve_y_q;
  assign points_used_o = used_q;

endmodule

`default_nettype wire

// ----- sv/bezier_curve_point_eval.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_point_eval: Bezier curve point evaluator
// Collects 2-D control points and evaluates the Bezier curve at t by the
// de Casteljau recurrence in widened fixed point.
// ----------------------------------------------------------------------------
// An append transfer stores the point unless the store already holds
// MaxPoints points. An evaluate transfer with n stored points first reads
// the n store entries, then works through one level of the recurrence after
// another, each lerp passing through a multiply step and an add step on the
// shared multiply and add unit, plus a move step per level to realign the
// work row. The result waits in an output register, so appends are taken
// while it is pending. Outputs are signed Q16.0 integers, rounded to
// nearest with halves up and saturated.
`default_nettype none

module bezier_curve_point_eval
  import bcpe_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bcpe_in_if.sink    in_i,
  bcpe_out_if.source out_o
);

  localparam int AW   = $clog2(MaxPoints);
  localparam int CW   = $clog2(MaxPoints + 1);
  localparam int EXTW = (CoordBits > FieldW) ? CoordBits : FieldW;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr, load_idx, tail;
  logic [CW-1:0]   cnt;
  logic [2*CoordBits-1:0] ram_wdata, ram_rdata;
  logic [EXTW-1:0] px_ext, py_ext;
  bcpe_cmd_t       cmd;

  // input coordinates reduced to the internal coordinate width
  assign px_ext    = EXTW'($unsigned(in_i.point_x));
  assign py_ext    = EXTW'($unsigned(in_i.point_y));
  assign ram_wdata = {py_ext[CoordBits-1:0], px_ext[CoordBits-1:0]};

  bcpe_ram #(
    .Width (2 * CoordBits),
    .Depth (MaxPoints)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bcpe_ctrl #(
    .MaxPoints (MaxPoints)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr),
    .load_idx_o  (load_idx),
    .tail_o      (tail),
    .cnt_o       (cnt),
    .cmd_o       (cmd)
  );

  bcpe_dpath #(
    .MaxPoints (MaxPoints),
    .CoordBits (CoordBits)
  ) u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .param_t_i     (in_i.param_t),
    .ram_rdata_i   (ram_rdata),
    .load_idx_i    (load_idx),
    .tail_i        (tail),
    .cnt_i         (cnt),
    .curve_x_o     (out_o.curve_x),
    .curve_y_o     (out_o.curve_y),
    .points_used_o (out_o.points_used)
  );

endmodule

`default_nettype wire

// ----- dv/tb_bezier_curve_point_eval.sv -----
// ----------------------------------------------------------------------------
// tb_bezier_curve_point_eval: testbench for the Bezier curve point evaluator
// A directed stimulus table, then random appends and evaluations. A
// de Casteljau predictor produces the expected curve points, and each
// result transfer is checked field by field. The sender runs in bursts, and
// the receiver stalls on patterns of its own plus one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_bezier_curve_point_eval;
  import bcpe_pkg::*;

  localparam int NumPts    = MaxPointsDef;
  localparam int RandItems = 1700;
  localparam int CycLimit  = 3000000;
  localparam int HoldCyc   = 3000;
  localparam int DirRows   = 16;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [4:0]         used;
  } curve_pt_t;

  typedef struct {
    logic               cmd;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [16:0]        t;
    bit                 typed;  // expectation written in the row
    curve_pt_t          pt;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  bcpe_in_if  in_ch ();
  bcpe_out_if out_ch ();

  bezier_curve_point_eval u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state: control points held so far
  longint    ctl_x [NumPts];
  longint    ctl_y [NumPts];
  int        pts_held;
  curve_pt_t curve_q [$];
  int        err_cnt;
  int        sent_cnt;
  logic      hold_off;
  longint    cyc_cnt;

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // one rounded lerp step of the recurrence, 14 fraction bits
  function automatic longint lerp_step(longint a, longint b, longint t);
    longint v;
    v = a * (65536 - t) + b * t + 32768;
    return v >>> 16;
  endfunction

  function automatic logic signed [15:0] to_coord(longint v);
    longint r;
    r = (v + 8192) >>> FracExtra;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Bezier point over the held control points
  function automatic curve_pt_t curve_at(logic [16:0] t_in);
    curve_pt_t r;
    longint    wx [NumPts];
    longint    wy [NumPts];
    longint    t;
    t = (t_in > TOne) ? 65536 : longint'(t_in);
    r.used = pts_held[4:0];
    if (pts_held == 0) begin
      r.x = '0;
      r.y = '0;
      return r;
    end
    for (int i = 0; i < pts_held; i++) begin
      wx[i] = ctl_x[i] <<< FracExtra;
      wy[i] = ctl_y[i] <<< FracExtra;
    end
    for (int lvl = pts_held - 1; lvl > 0; lvl--) begin
      for (int i = 0; i < lvl; i++) begin
        wx[i] = lerp_step(wx[i], wx[i+1], t);
        wy[i] = lerp_step(wy[i], wy[i+1], t);
      end
    end
    r.x = to_coord(wx[0]);
    r.y = to_coord(wy[0]);
    return r;
  endfunction

  // update the predictor for one accepted transfer
  task automatic take_item(stim_row_t row);
    if (row.cmd == CmdAppend) begin
      if (pts_held < NumPts) begin
        ctl_x[pts_held] = row.px;
        ctl_y[pts_held] = row.py;
        pts_held++;
      end
    end else if (row.typed) begin
      curve_q.insert(curve_q.size(), row.pt);
    end else begin
      curve_q.insert(curve_q.size(), curve_at(row.t));
    end
  endtask

  // burst/gap sender state
  int burst_left;

  task automatic send_row(stim_row_t row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= row.cmd;
    in_ch.point_x <= row.px;
    in_ch.point_y <= row.py;
    in_ch.param_t <= row.t;
    do @(posedge clk_i); while (!in_ch.ready);
    take_item(row);
    sent_cnt++;
    burst_left--;
  endtask

  function automatic stim_row_t mk(logic c, int x, int y, int t, bit typed,
                                   int ex, int ey, int eu);
    stim_row_t r;
    r.cmd     = c;
    r.px      = x[15:0];
    r.py      = y[15:0];
    r.t       = t[16:0];
    r.typed   = typed;
    r.pt.x    = ex[15:0];
    r.pt.y    = ey[15:0];
    r.pt.used = eu[4:0];
    return r;
  endfunction

  // stimulus
  initial begin
    stim_row_t dir_tbl [DirRows];
    stim_row_t row;
    int        pick;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CmdAppend;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.param_t = '0;
    rst_ni        = 1'b0;
    pts_held      = 0;
    err_cnt       = 0;
    sent_cnt      = 0;
    burst_left    = 0;

    // empty store gives the origin, one point gives that point
    dir_tbl[0]  = mk(CmdEval,   0, 0, 0,      1, 0, 0, 0);
    dir_tbl[1]  = mk(CmdEval,   0, 0, 65536,  1, 0, 0, 0);
    dir_tbl[2]  = mk(CmdAppend, 32767, -32768, 0, 0, 0, 0, 0);
    dir_tbl[3]  = mk(CmdEval,   0, 0, 32768,  1, 32767, -32768, 1);
    dir_tbl[4]  = mk(CmdEval,   0, 0, 131071, 1, 32767, -32768, 1);
    dir_tbl[5]  = mk(CmdAppend, -32768, 32767, 0, 0, 0, 0, 0);
    dir_tbl[6]  = mk(CmdEval,   0, 0, 0,      1, 32767, -32768, 2);
    dir_tbl[7]  = mk(CmdEval,   0, 0, 65536,  1, -32768, 32767, 2);
    dir_tbl[8]  = mk(CmdEval,   0, 0, 32768,  0, 0, 0, 0);
    dir_tbl[9]  = mk(CmdEval,   0, 0, 131071, 1, -32768, 32767, 2);
    dir_tbl[10] = mk(CmdAppend, 0, 0, 0,      0, 0, 0, 0);
    dir_tbl[11] = mk(CmdAppend, -1, -1, 0,    0, 0, 0, 0);
    dir_tbl[12] = mk(CmdAppend, 21845, -21846, 0, 0, 0, 0, 0);
    dir_tbl[13] = mk(CmdEval,   0, 0, 1,      0, 0, 0, 0);
    dir_tbl[14] = mk(CmdEval,   0, 0, 65535,  0, 0, 0, 0);
    dir_tbl[15] = mk(CmdEval,   0, 0, 98304,  0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_row(dir_tbl[i]);

    // random: fill the store, then mostly evaluations; a full store drops points
    for (int n = 0; n < RandItems; n++) begin
      row.typed = 1'b0;
      row.pt    = '{default: '0};
      row.px    = 16'($urandom);
      row.py    = 16'($urandom);
      pick      = $urandom_range(0, 99);
      row.cmd   = (pick < (pts_held < NumPts ? 50 : 15)) ? CmdAppend : CmdEval;
      pick      = $urandom_range(0, 9);
      if (pick == 0)      row.t = 17'd0;
      else if (pick == 1) row.t = TOne;
      else if (pick == 2) row.t = 17'($urandom_range(65537, 131071));
      else                row.t = 17'($urandom_range(0, 65536));
      send_row(row);
    end
    in_ch.valid <= 1'b0;

    wait (curve_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_bezier_curve_point_eval: done, clean");
    end else begin
      $display("tb_bezier_curve_point_eval: done, errors");
    end
    $finish;
  end

  // one long receiver hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (sent_cnt >= 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCyc) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // receiver: stall pattern changes every stretch; check each transfer
  int        rx_mode;
  int        rx_left;
  curve_pt_t want;

  initial begin
    out_ch.ready = 1'b0;
    rx_mode      = 0;
    rx_left      = 0;
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (curve_q.size() == 0) begin
        $display("%0t: result with nothing expected: x=%0d y=%0d used=%0d", $time,
                 out_ch.curve_x, out_ch.curve_y, out_ch.points_used);
        err_cnt++;
      end else begin
        want = curve_q.pop_front();
        if (out_ch.curve_x !== want.x) begin
          $display("%0t: curve_x expected %0d got %0d", $time, want.x, out_ch.curve_x);
          err_cnt++;
        end
        if (out_ch.curve_y !== want.y) begin
          $display("%0t: curve_y expected %0d got %0d", $time, want.y, out_ch.curve_y);
          err_cnt++;
        end
        if (out_ch.points_used !== want.used) begin
          $display("%0t: points_used expected %0d got %0d", $time, want.used,
                   out_ch.points_used);
          err_cnt++;
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 400);
    end
    rx_left--;
    if (hold_off)          out_ch.ready <= 1'b0;
    else if (rx_mode == 0) out_ch.ready <= 1'b1;
    else if (rx_mode == 1) out_ch.ready <= 1'($urandom_range(0, 1));
    else                   out_ch.ready <= ($urandom_range(0, 3) == 0);
  end

  // run limit
  initial cyc_cnt = 0;

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycLimit) begin
      $display("tb_bezier_curve_point_eval: done, errors");
      $finish;
    end
  end

endmodule

`default_nettype wire
